### rtl/sparse_row_store_get_set_defines.svh
// ----------------------------------------------------------------------------
// Sparse row store assertion macros
// Shared assertion helpers for the sparse row store. Each macro expects
// clk_i and rst_ni to be in scope. Defining ASSERT_OFF removes all checks.
// ----------------------------------------------------------------------------
`ifndef SPARSE_ROW_STORE_GET_SET_DEFINES_SVH
`define SPARSE_ROW_STORE_GET_SET_DEFINES_SVH

`ifndef ASSERT_OFF

// Plain property, checked on every rising clock edge outside of reset.
`define SRS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication, checked outside of reset.
`define SRS_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`else

`define SRS_ASSERT(lbl, prop, msg)
`define SRS_ASSERT_IMPL(lbl, pre, post, msg)

`endif

`endif

### rtl/srs_pkg.sv
// ----------------------------------------------------------------------------
// Sparse row store package
// Field widths, codes, state encoding and the structs that pass between the
// top level and the sequencer core.
// ----------------------------------------------------------------------------
package srs_pkg;

  // Field widths of one beat.
  localparam int ROW_W      = 9;
  localparam int COL_W      = 9;
  localparam int VAL_W      = 64;
  localparam int STATUS_W   = 2;
  localparam int TOTAL_W    = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [VAL_W-1:0] val_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  // Reset value of both dimension registers.
  localparam row_t DIM_RESET = 9'd256;

  // Action codes.
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } srs_status_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_GET_END,
    ST_GET_START,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_DECIDE,
    ST_SHIFT,
    ST_PLACE,
    ST_BUMP,
    ST_RESULT
  } srs_state_e;

  // What a located item turns into.
  typedef enum logic [2:0] {
    OP_READ,
    OP_OVERWRITE,
    OP_REMOVE,
    OP_INSERT,
    OP_FULL,
    OP_NONE
  } srs_op_e;

  typedef struct packed {
    logic action;
    row_t row_number;
    col_t column_number;
    val_t write_value;
  } srs_item_t;

  typedef struct packed {
    val_t                 read_value;
    srs_status_e          status;
    logic [TOTAL_W-1:0]   nonzero_total;
  } srs_res_t;

  // Effective matrix dimensions, already clipped to the build limits.
  typedef struct packed {
    row_t rows;
    col_t cols;
  } srs_dims_t;

endpackage

### rtl/srs_if.sv
// ----------------------------------------------------------------------------
// Sparse row store channels
// Valid/ready channels for the item beats going in and the result beats
// coming out.
// ----------------------------------------------------------------------------
interface srs_in_if;
  logic          valid;
  logic          ready;
  logic          action;
  srs_pkg::row_t row_number;
  srs_pkg::col_t column_number;
  srs_pkg::val_t write_value;

  modport source (output valid, action, row_number, column_number, write_value,
                  input ready);
  modport sink (input valid, action, row_number, column_number, write_value,
                output ready);
endinterface

interface srs_out_if;
  logic                          valid;
  logic                          ready;
  srs_pkg::val_t                 read_value;
  logic [srs_pkg::STATUS_W-1:0]  status;
  logic [srs_pkg::TOTAL_W-1:0]   nonzero_total;

  modport source (output valid, read_value, status, nonzero_total, input ready);
  modport sink (input valid, read_value, status, nonzero_total, output ready);
endinterface

### rtl/srs_core.sv
// ----------------------------------------------------------------------------
// Sparse row store sequencer core
// Holds the entry memory and the row start memory and walks one item at a
// time through lookup, scan, entry shift and row start sweep.
// ----------------------------------------------------------------------------
`include "sparse_row_store_get_set_defines.svh"

module srs_core #(
  parameter int MAX_ROWS       = 256,
  parameter int ENTRY_CAPACITY = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srs_pkg::srs_dims_t dims_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  srs_pkg::srs_item_t item_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output srs_pkg::srs_res_t  res_o
);

  localparam int CW  = $clog2(ENTRY_CAPACITY + 1);
  localparam int AW  = (ENTRY_CAPACITY > 1) ? $clog2(ENTRY_CAPACITY) : 1;
  localparam int RAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RXW = (RAW > srs_pkg::ROW_W) ? RAW : srs_pkg::ROW_W;
  localparam int TXW = (CW > srs_pkg::TOTAL_W) ? CW : srs_pkg::TOTAL_W;
  localparam int EW  = srs_pkg::COL_W + srs_pkg::VAL_W;

  localparam logic [CW-1:0]  CAP_C    = CW'(ENTRY_CAPACITY);
  localparam logic [RAW-1:0] LAST_ROW = RAW'(MAX_ROWS - 1);

  srs_pkg::srs_state_e state_q, state_d;
  srs_pkg::srs_op_e    op;

  // Item and lookup registers.
  logic                  action_q, action_d;
  srs_pkg::row_t         row_q, row_d;
  srs_pkg::col_t         col_q, col_d;
  srs_pkg::val_t         wval_q, wval_d;
  logic [CW-1:0]         total_q, total_d;
  logic [CW-1:0]         pos_q, pos_d;
  logic [CW-1:0]         end_q, end_d;
  logic                  found_q, found_d;
  logic                  up_q, up_d;
  srs_pkg::val_t         rval_q, rval_d;
  srs_pkg::srs_status_e  status_q, status_d;

  // Sweep pointers and pending writes.
  logic [RAW-1:0]        clr_q, clr_d;
  logic [CW-1:0]         ent_ptr_q, ent_ptr_d;
  logic [AW-1:0]         ent_wa_q, ent_wa_d;
  logic                  ent_pend_q, ent_pend_d;
  logic [RAW-1:0]        row_ptr_q, row_ptr_d;
  logic [RAW-1:0]        rs_wa_q, rs_wa_d;
  logic                  rs_pend_q, rs_pend_d;
  logic                  bmp_more_q, bmp_more_d;

  // Memory ports.
  logic [EW-1:0]         ent_mem [ENTRY_CAPACITY];
  logic                  ent_re, ent_we;
  logic [AW-1:0]         ent_raddr, ent_waddr;
  logic [EW-1:0]         ent_wdata, ent_rdata_q;
  logic [CW-1:0]         rs_mem [MAX_ROWS];
  logic                  rs_re, rs_we;
  logic [RAW-1:0]        rs_raddr, rs_waddr;
  logic [CW-1:0]         rs_wdata, rs_rdata_q;

  // Derived conditions.
  logic [RXW-1:0]        row_x;
  logic [RAW-1:0]        row_addr_end, row_addr_start;
  logic                  in_range, row_first, scan_more, wzero, full;
  srs_pkg::col_t         ent_col;
  logic                  ent_hit, ent_past;
  logic [CW:0]           ptr_inc_w;
  logic [CW-1:0]         ent_ptr_next;
  logic                  mv_more;
  logic [TXW-1:0]        total_x;

  assign row_x          = RXW'(row_q);
  assign row_addr_end   = RAW'(row_x - RXW'(1));
  assign row_addr_start = RAW'(row_x - RXW'(2));
  assign in_range       = (row_q != '0) && (col_q != '0) &&
                          (row_q <= dims_i.rows) && (col_q <= dims_i.cols);
  assign row_first      = (row_q == srs_pkg::row_t'(1));
  assign scan_more      = (pos_q < end_q);
  assign wzero          = (wval_q[srs_pkg::VAL_W-2:0] == '0);
  assign full           = (total_q == CAP_C);
  assign ent_col        = ent_rdata_q[EW-1:srs_pkg::VAL_W];
  assign ent_hit        = (ent_col == col_q);
  assign ent_past       = (ent_col > col_q);

  // Shared pointer step: up moves toward lower entries on an insert.
  assign ptr_inc_w    = {1'b0, ent_ptr_q} + (CW+1)'(1);
  assign ent_ptr_next = up_q ? (ent_ptr_q - CW'(1)) : ptr_inc_w[CW-1:0];
  assign mv_more      = up_q ? (ent_ptr_q > pos_q) : (ptr_inc_w < {1'b0, total_q});

  // Classify the located item.
  always_comb begin
    if (action_q == srs_pkg::ACT_READ) begin
      op = srs_pkg::OP_READ;
    end else if (found_q && wzero) begin
      op = srs_pkg::OP_REMOVE;
    end else if (found_q) begin
      op = srs_pkg::OP_OVERWRITE;
    end else if (wzero) begin
      op = srs_pkg::OP_NONE;
    end else if (full) begin
      op = srs_pkg::OP_FULL;
    end else begin
      op = srs_pkg::OP_INSERT;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srs_pkg::ST_CLEAR: begin
        if (clr_q == LAST_ROW) state_d = srs_pkg::ST_IDLE;
      end
      srs_pkg::ST_IDLE: begin
        if (item_valid_i) state_d = srs_pkg::ST_CHECK;
      end
      srs_pkg::ST_CHECK: begin
        state_d = in_range ? srs_pkg::ST_GET_END : srs_pkg::ST_RESULT;
      end
      srs_pkg::ST_GET_END: begin
        state_d = row_first ? srs_pkg::ST_SCAN : srs_pkg::ST_GET_START;
      end
      srs_pkg::ST_GET_START: state_d = srs_pkg::ST_SCAN;
      srs_pkg::ST_SCAN: begin
        state_d = scan_more ? srs_pkg::ST_SCAN_CMP : srs_pkg::ST_DECIDE;
      end
      srs_pkg::ST_SCAN_CMP: begin
        state_d = (ent_hit || ent_past) ? srs_pkg::ST_DECIDE : srs_pkg::ST_SCAN;
      end
      srs_pkg::ST_DECIDE: begin
        if (op == srs_pkg::OP_REMOVE || op == srs_pkg::OP_INSERT) begin
          state_d = srs_pkg::ST_SHIFT;
        end else begin
          state_d = srs_pkg::ST_RESULT;
        end
      end
      srs_pkg::ST_SHIFT: begin
        if (!mv_more) state_d = up_q ? srs_pkg::ST_PLACE : srs_pkg::ST_BUMP;
      end
      srs_pkg::ST_PLACE: state_d = srs_pkg::ST_BUMP;
      srs_pkg::ST_BUMP: begin
        if (!bmp_more_q) state_d = srs_pkg::ST_RESULT;
      end
      srs_pkg::ST_RESULT: begin
        if (res_ready_i) state_d = srs_pkg::ST_IDLE;
      end
      default: state_d = srs_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory controls and handshake outputs.
  always_comb begin
    action_d   = action_q;
    row_d      = row_q;
    col_d      = col_q;
    wval_d     = wval_q;
    total_d    = total_q;
    pos_d      = pos_q;
    end_d      = end_q;
    found_d    = found_q;
    up_d       = up_q;
    rval_d     = rval_q;
    status_d   = status_q;
    clr_d      = clr_q;
    ent_ptr_d  = ent_ptr_q;
    ent_wa_d   = ent_wa_q;
    ent_pend_d = ent_pend_q;
    row_ptr_d  = row_ptr_q;
    rs_wa_d    = rs_wa_q;
    rs_pend_d  = rs_pend_q;
    bmp_more_d = bmp_more_q;
    ent_re     = 1'b0;
    ent_raddr  = pos_q[AW-1:0];
    ent_we     = 1'b0;
    ent_waddr  = pos_q[AW-1:0];
    ent_wdata  = {col_q, wval_q};
    rs_re      = 1'b0;
    rs_raddr   = row_addr_end;
    rs_we      = 1'b0;
    rs_waddr   = rs_wa_q;
    rs_wdata   = up_q ? (rs_rdata_q + CW'(1)) : (rs_rdata_q - CW'(1));
    item_ready_o = 1'b0;
    res_valid_o  = 1'b0;

    unique case (state_q)
      srs_pkg::ST_CLEAR: begin
        // Clearing pass over the row start memory.
        rs_we    = 1'b1;
        rs_waddr = clr_q;
        rs_wdata = '0;
        clr_d    = clr_q + RAW'(1);
      end
      srs_pkg::ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          action_d = item_i.action;
          row_d    = item_i.row_number;
          col_d    = item_i.column_number;
          wval_d   = item_i.write_value;
        end
      end
      srs_pkg::ST_CHECK: begin
        found_d  = 1'b0;
        rval_d   = '0;
        status_d = in_range ? srs_pkg::STATUS_OK : srs_pkg::STATUS_RANGE;
        rs_re    = in_range;
        rs_raddr = row_addr_end;
      end
      srs_pkg::ST_GET_END: begin
        end_d = (rs_rdata_q > total_q) ? total_q : rs_rdata_q;
        if (row_first) begin
          pos_d = '0;
        end else begin
          rs_re    = 1'b1;
          rs_raddr = row_addr_start;
        end
      end
      srs_pkg::ST_GET_START: pos_d = rs_rdata_q;
      srs_pkg::ST_SCAN: begin
        ent_re    = scan_more;
        ent_raddr = pos_q[AW-1:0];
      end
      srs_pkg::ST_SCAN_CMP: begin
        if (ent_hit) begin
          found_d = 1'b1;
          if (action_q == srs_pkg::ACT_READ) rval_d = ent_rdata_q[srs_pkg::VAL_W-1:0];
        end else if (!ent_past) begin
          pos_d = pos_q + CW'(1);
        end
      end
      srs_pkg::ST_DECIDE: begin
        unique case (op)
          srs_pkg::OP_OVERWRITE: begin
            ent_we    = 1'b1;
            ent_waddr = pos_q[AW-1:0];
          end
          srs_pkg::OP_FULL: status_d = srs_pkg::STATUS_FULL;
          srs_pkg::OP_REMOVE: begin
            up_d      = 1'b0;
            ent_ptr_d = pos_q;
          end
          srs_pkg::OP_INSERT: begin
            up_d      = 1'b1;
            ent_ptr_d = total_q;
          end
          default: ;
        endcase
      end
      srs_pkg::ST_SHIFT: begin
        // One entry move per cycle: read the neighbor, write it next cycle.
        if (ent_pend_q) begin
          ent_we    = 1'b1;
          ent_waddr = ent_wa_q;
          ent_wdata = ent_rdata_q;
        end
        if (mv_more) begin
          ent_re     = 1'b1;
          ent_raddr  = ent_ptr_next[AW-1:0];
          ent_wa_d   = ent_ptr_q[AW-1:0];
          ent_pend_d = 1'b1;
          ent_ptr_d  = ent_ptr_next;
        end else begin
          ent_pend_d = 1'b0;
          if (!up_q) begin
            total_d    = total_q - CW'(1);
            row_ptr_d  = row_addr_end;
            bmp_more_d = 1'b1;
            rs_pend_d  = 1'b0;
          end
        end
      end
      srs_pkg::ST_PLACE: begin
        ent_we     = 1'b1;
        ent_waddr  = pos_q[AW-1:0];
        total_d    = total_q + CW'(1);
        row_ptr_d  = row_addr_end;
        bmp_more_d = 1'b1;
        rs_pend_d  = 1'b0;
      end
      srs_pkg::ST_BUMP: begin
        // Row starts from the addressed row to the last one step by one.
        rs_we = rs_pend_q;
        if (bmp_more_q) begin
          rs_re     = 1'b1;
          rs_raddr  = row_ptr_q;
          rs_wa_d   = row_ptr_q;
          rs_pend_d = 1'b1;
          if (row_ptr_q == LAST_ROW) begin
            bmp_more_d = 1'b0;
          end else begin
            row_ptr_d = row_ptr_q + RAW'(1);
          end
        end else begin
          rs_pend_d = 1'b0;
        end
      end
      srs_pkg::ST_RESULT: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  assign total_x                = TXW'(total_q);
  assign res_o.read_value       = rval_q;
  assign res_o.status           = status_q;
  assign res_o.nonzero_total    = total_x[srs_pkg::TOTAL_W-1:0];

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= srs_pkg::ST_CLEAR;
      total_q    <= '0;
      clr_q      <= '0;
      ent_pend_q <= 1'b0;
      rs_pend_q  <= 1'b0;
      bmp_more_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      total_q    <= total_d;
      clr_q      <= clr_d;
      ent_pend_q <= ent_pend_d;
      rs_pend_q  <= rs_pend_d;
      bmp_more_q <= bmp_more_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    action_q  <= action_d;
    row_q     <= row_d;
    col_q     <= col_d;
    wval_q    <= wval_d;
    pos_q     <= pos_d;
    end_q     <= end_d;
    found_q   <= found_d;
    up_q      <= up_d;
    rval_q    <= rval_d;
    status_q  <= status_d;
    ent_ptr_q <= ent_ptr_d;
    ent_wa_q  <= ent_wa_d;
    row_ptr_q <= row_ptr_d;
    rs_wa_q   <= rs_wa_d;
  end

  // Entry memory: column number over value, registered read.
  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (ent_re) ent_rdata_q <= ent_mem[ent_raddr];
  end

  // Row start memory: entry of row r holds the start of row r+1.
  always_ff @(posedge clk_i) begin
    if (rs_we) rs_mem[rs_waddr] <= rs_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (rs_re) rs_rdata_q <= rs_mem[rs_raddr];
  end

  // The entry count never passes the capacity.
  `SRS_ASSERT(a_total_cap, total_q <= CAP_C, "entry count above capacity")
  // The count moves by at most one per cycle.
  `SRS_ASSERT_IMPL(a_total_step, total_q != $past(total_q), (total_q - $past(total_q)) == CW'(1) || ($past(total_q) - total_q) == CW'(1), "entry count jumped")
  // A full flag only comes from a store that is really full.
  `SRS_ASSERT_IMPL(a_full_real, state_q == srs_pkg::ST_DECIDE && op == srs_pkg::OP_FULL, total_q == CAP_C, "full reported below capacity")
  // Entry moves never read the entry being written.
  `SRS_ASSERT_IMPL(a_ent_rw, ent_we && ent_re, ent_waddr != ent_raddr, "entry memory read and write collide")
  // The row start sweep never reads the row start being written.
  `SRS_ASSERT_IMPL(a_rs_rw, rs_we && rs_re, rs_waddr != rs_raddr, "row start memory read and write collide")
  // A compare only looks at an entry inside the addressed row.
  `SRS_ASSERT_IMPL(a_scan_bound, state_q == srs_pkg::ST_SCAN_CMP, pos_q < end_q, "scan left the row")

endmodule

### rtl/sparse_row_store_get_set.sv
// ----------------------------------------------------------------------------
// Sparse row store with single entry get and set
// Compressed-row sparse matrix of 64-bit words with per-entry read, write,
// insert and remove, plus dimension registers and a registered result beat.
//
//   channel   dir  handshake              payload
//   in_chan   in   valid/ready            action, row_number, column_number,
//                                         write_value
//   out_chan  out  valid/ready            read_value, status, nonzero_total
//   cfg       in   cfg_we_i, no stall     cfg_index_i, cfg_data_i
//
// Each item is range checked; one out of range skips to its result. Else the
// row end and, past row 1, the row start are read and the row's entries are
// compared until the column is found or passed. Removal and insert then shift
// the later entries one by one, and both step the row starts from the addressed
// row to MAX_ROWS, as each memory has one read and one write port. After reset
// a clearing pass zeroes the row starts. A full output register stalls the core.
// ----------------------------------------------------------------------------
module sparse_row_store_get_set #(
  parameter int MAX_ROWS       = 256,
  parameter int MAX_COLS       = 256,
  parameter int ENTRY_CAPACITY = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  srs_in_if.sink                           in_chan,
  srs_out_if.source                        out_chan,
  input  logic                             cfg_we_i,
  input  logic [srs_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [srs_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  srs_pkg::row_t      row_count_q;
  srs_pkg::col_t      column_count_q;
  srs_pkg::srs_dims_t dims;
  srs_pkg::srs_item_t item;
  srs_pkg::srs_res_t  res, out_res_q;
  logic               res_valid, res_ready;
  logic               item_ready;
  logic               out_valid_q;

  // Dimension registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= srs_pkg::DIM_RESET;
      column_count_q <= srs_pkg::DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        srs_pkg::REG_ROW_COUNT:    row_count_q    <= cfg_data_i;
        srs_pkg::REG_COLUMN_COUNT: column_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clip the dimensions to what the store was built for.
  assign dims.rows = (32'(row_count_q) > MAX_ROWS) ? srs_pkg::row_t'(MAX_ROWS)
                                                   : row_count_q;
  assign dims.cols = (32'(column_count_q) > MAX_COLS) ? srs_pkg::col_t'(MAX_COLS)
                                                      : column_count_q;

  assign item.action        = in_chan.action;
  assign item.row_number    = in_chan.row_number;
  assign item.column_number = in_chan.column_number;
  assign item.write_value   = in_chan.write_value;
  assign in_chan.ready      = item_ready;

  srs_core #(
    .MAX_ROWS       (MAX_ROWS),
    .ENTRY_CAPACITY (ENTRY_CAPACITY)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dims_i       (dims),
    .item_valid_i (in_chan.valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_o        (res)
  );

  // Output register: takes a new beat when empty or being drained.
  assign res_ready = !out_valid_q || out_chan.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_res_q <= res;
  end

  assign out_chan.valid         = out_valid_q;
  assign out_chan.read_value    = out_res_q.read_value;
  assign out_chan.status        = out_res_q.status;
  assign out_chan.nonzero_total = out_res_q.nonzero_total;

endmodule
